FILE: rtl/caldate_pkg.sv
// calendar date counter package: opcode codes, field widths and month length table
// used by calendar_date_counter_core; no dependencies
package caldate_pkg;

  localparam int OP_W       = 4;
  localparam int VALUE_W    = 14;
  localparam int DAY_W      = 5;
  localparam int MONTH_W    = 4;
  localparam int YEAR_OUT_W = 14;

  localparam logic [DAY_W-1:0]   FIRST_DAY   = 5'd1;
  localparam logic [DAY_W-1:0]   LAST_DAY    = 5'd31;
  localparam logic [MONTH_W-1:0] FIRST_MONTH = 4'd1;
  localparam logic [MONTH_W-1:0] LAST_MONTH  = 4'd12;
  localparam int                 YEAR_RESET  = 2026;

  // year mod 25 residue, with 4 and 16 from the low bits this gives the 100/400 rule
  localparam int R25_W       = 5;
  localparam int QUOT_W      = 10;
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 17;
  localparam logic [RECIP_W-1:0] RECIP25  = 13'd5243;
  localparam logic [R25_W-1:0]   R25_LAST = 5'd24;
  localparam logic [R25_W-1:0]   R25_RESET = R25_W'(YEAR_RESET % 25);

  typedef enum logic [OP_W-1:0] {
    OP_NEXT_DAY   = 4'd0,
    OP_PREV_DAY   = 4'd1,
    OP_NEXT_MONTH = 4'd2,
    OP_PREV_MONTH = 4'd3,
    OP_NEXT_YEAR  = 4'd4,
    OP_PREV_YEAR  = 4'd5,
    OP_SET_DAY    = 4'd6,
    OP_SET_MONTH  = 4'd7,
    OP_SET_YEAR   = 4'd8
  } op_t;

  function automatic logic is_leap(input logic [3:0] low_bits, input logic div25);
    is_leap = (low_bits[1:0] == 2'd0) && (!div25 || (low_bits == 4'd0));
  endfunction

  function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                               input logic leap_year);
    logic [DAY_W-1:0] len;
    case (m) inside
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = leap_year ? 5'd29 : 5'd28;
      default:                 len = LAST_DAY;
    endcase
    days_in = len;
  endfunction

endpackage

FILE: rtl/calendar_date_counter_core.sv
// calendar date counter core: gregorian date register with step and set commands
// depends on caldate_pkg
//
// Takes one command word per cycle while cmd_stall is low and returns one
// result word per command, through the input register and then the date and
// result registers. The date state doubles as the result register, so a
// stalled result holds the date while one more command waits in the input
// register. The input register also holds the reciprocal-multiply quotient of
// value by 25, which sets the longest path; the year is tracked together with
// its residue mod 25 so leap years need no divider. Years stay within
// 1..YEAR_MAX; the year port shows the low 14 bits.
module calendar_date_counter_core #(
  parameter int YEAR_MAX = 16383
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cmd_valid,
  output logic                               cmd_stall,
  input  logic [caldate_pkg::OP_W-1:0]       opcode,
  input  logic [caldate_pkg::VALUE_W-1:0]    value,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output logic [caldate_pkg::DAY_W-1:0]      day,
  output logic [caldate_pkg::MONTH_W-1:0]    month,
  output logic [caldate_pkg::YEAR_OUT_W-1:0] year,
  output logic                               leap,
  output logic                               applied
);
  import caldate_pkg::*;

  localparam int YW = $clog2(YEAR_MAX + 1);
  localparam logic [YW-1:0] YEAR_TOP   = YW'(YEAR_MAX);
  localparam logic [YW-1:0] YEAR_ONE   = YW'(1);
  localparam logic [YW-1:0] YEAR_START = YW'(YEAR_RESET);

  // input register
  logic               stage_valid;
  op_t                stage_op;
  logic [VALUE_W-1:0] stage_value;
  logic [QUOT_W-1:0]  stage_quot;

  // date state, also the result register
  logic [DAY_W-1:0]   day_reg;
  logic [MONTH_W-1:0] month_reg;
  logic [YW-1:0]      year_reg;
  logic [R25_W-1:0]   r25;
  logic               leap_reg;
  logic               applied_reg;

  logic [DAY_W-1:0]   day_next;
  logic [MONTH_W-1:0] month_next;
  logic [YW-1:0]      year_next;
  logic [R25_W-1:0]   r25_next;
  logic               leap_next;
  logic               applied_next;

  logic                        take;
  logic [VALUE_W+RECIP_W-1:0]  quot_prod;
  logic [YW-1:0]               year_inc;
  logic [YW-1:0]               year_dec;
  logic [R25_W-1:0]            r25_inc;
  logic [R25_W-1:0]            r25_dec;
  logic [R25_W-1:0]            r25_val;
  logic [VALUE_W-1:0]          val_rem;
  logic                        leap_inc;
  logic                        leap_dec;
  logic                        leap_val;
  logic                        year_set_ok;
  logic [DAY_W-1:0]            dim_cur;
  logic [DAY_W-1:0]            day_pre;
  logic [DAY_W-1:0]            day_lim;

  assign take      = stage_valid && (!rsp_valid || !rsp_stall);
  assign cmd_stall = stage_valid && !take;
  assign quot_prod = (VALUE_W+RECIP_W)'(value) * (VALUE_W+RECIP_W)'(RECIP25);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!cmd_stall) begin
      stage_valid <= cmd_valid;
    end
    if (cmd_valid && !cmd_stall) begin
      stage_op    <= op_t'(opcode);
      stage_value <= value;
      stage_quot  <= quot_prod[RECIP_SHIFT +: QUOT_W];
    end
  end

  // neighbor years and their leap flags
  assign year_inc = year_reg + YEAR_ONE;
  assign year_dec = year_reg - YEAR_ONE;
  assign r25_inc  = (r25 == R25_LAST) ? '0 : r25 + R25_W'(1);
  assign r25_dec  = (r25 == '0) ? R25_LAST : r25 - R25_W'(1);
  assign leap_inc = is_leap(year_inc[3:0], r25_inc == '0);
  assign leap_dec = is_leap(year_dec[3:0], r25_dec == '0);

  assign val_rem  = stage_value - VALUE_W'(VALUE_W'(stage_quot) * VALUE_W'(25));
  assign r25_val  = R25_W'(val_rem);
  assign leap_val = is_leap(stage_value[3:0], r25_val == '0);
  assign year_set_ok = (stage_value != '0) &&
                       ({{(32-VALUE_W){1'b0}}, stage_value} <= 32'(YEAR_MAX));

  assign dim_cur = days_in(month_reg, leap_reg);

  always_comb begin
    day_pre      = day_reg;
    month_next   = month_reg;
    year_next    = year_reg;
    r25_next     = r25;
    leap_next    = leap_reg;
    applied_next = 1'b0;
    unique case (stage_op)
      OP_NEXT_DAY: begin
        if (day_reg < dim_cur) begin
          day_pre      = day_reg + DAY_W'(1);
          applied_next = 1'b1;
        end else if (month_reg < LAST_MONTH) begin
          day_pre      = FIRST_DAY;
          month_next   = month_reg + MONTH_W'(1);
          applied_next = 1'b1;
        end else if (year_reg < YEAR_TOP) begin
          day_pre      = FIRST_DAY;
          month_next   = FIRST_MONTH;
          year_next    = year_inc;
          r25_next     = r25_inc;
          leap_next    = leap_inc;
          applied_next = 1'b1;
        end
      end
      OP_PREV_DAY: begin
        if (day_reg > FIRST_DAY) begin
          day_pre      = day_reg - DAY_W'(1);
          applied_next = 1'b1;
        end else if (month_reg > FIRST_MONTH) begin
          month_next   = month_reg - MONTH_W'(1);
          day_pre      = days_in(month_reg - MONTH_W'(1), leap_reg);
          applied_next = 1'b1;
        end else if (year_reg > YEAR_ONE) begin
          day_pre      = LAST_DAY;
          month_next   = LAST_MONTH;
          year_next    = year_dec;
          r25_next     = r25_dec;
          leap_next    = leap_dec;
          applied_next = 1'b1;
        end
      end
      OP_NEXT_MONTH: begin
        if (month_reg < LAST_MONTH) begin
          month_next   = month_reg + MONTH_W'(1);
          applied_next = 1'b1;
        end else if (year_reg < YEAR_TOP) begin
          month_next   = FIRST_MONTH;
          year_next    = year_inc;
          r25_next     = r25_inc;
          leap_next    = leap_inc;
          applied_next = 1'b1;
        end
      end
      OP_PREV_MONTH: begin
        if (month_reg > FIRST_MONTH) begin
          month_next   = month_reg - MONTH_W'(1);
          applied_next = 1'b1;
        end else if (year_reg > YEAR_ONE) begin
          month_next   = LAST_MONTH;
          year_next    = year_dec;
          r25_next     = r25_dec;
          leap_next    = leap_dec;
          applied_next = 1'b1;
        end
      end
      OP_NEXT_YEAR: begin
        if (year_reg < YEAR_TOP) begin
          year_next    = year_inc;
          r25_next     = r25_inc;
          leap_next    = leap_inc;
          applied_next = 1'b1;
        end
      end
      OP_PREV_YEAR: begin
        if (year_reg > YEAR_ONE) begin
          year_next    = year_dec;
          r25_next     = r25_dec;
          leap_next    = leap_dec;
          applied_next = 1'b1;
        end
      end
      OP_SET_DAY: begin
        if ((stage_value != '0) && (stage_value <= VALUE_W'(dim_cur))) begin
          day_pre      = DAY_W'(stage_value);
          applied_next = 1'b1;
        end
      end
      OP_SET_MONTH: begin
        if ((stage_value != '0) && (stage_value <= VALUE_W'(LAST_MONTH))) begin
          month_next   = MONTH_W'(stage_value);
          applied_next = 1'b1;
        end
      end
      OP_SET_YEAR: begin
        if (year_set_ok) begin
          year_next    = YW'(stage_value);
          r25_next     = r25_val;
          leap_next    = leap_val;
          applied_next = 1'b1;
        end
      end
      default: begin
        applied_next = 1'b0;
      end
    endcase
    // clamp to the length of the resulting month
    day_lim  = days_in(month_next, leap_next);
    day_next = (day_pre > day_lim) ? day_lim : day_pre;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid   <= 1'b0;
      day_reg     <= FIRST_DAY;
      month_reg   <= FIRST_MONTH;
      year_reg    <= YEAR_START;
      r25         <= R25_RESET;
      leap_reg    <= 1'b0;
      applied_reg <= 1'b0;
    end else begin
      if (take) begin
        rsp_valid   <= 1'b1;
        day_reg     <= day_next;
        month_reg   <= month_next;
        year_reg    <= year_next;
        r25         <= r25_next;
        leap_reg    <= leap_next;
        applied_reg <= applied_next;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign day     = day_reg;
  assign month   = month_reg;
  assign year    = YEAR_OUT_W'(year_reg);
  assign leap    = leap_reg;
  assign applied = applied_reg;

`ifndef SYNTH
  a_day_in_month: assert property (@(posedge clk) disable iff (rst)
    (day_reg >= FIRST_DAY) && (day_reg <= days_in(month_reg, leap_reg)))
    else $error("day outside current month");

  a_year_range: assert property (@(posedge clk) disable iff (rst)
    (year_reg >= YEAR_ONE) && (year_reg <= YEAR_TOP) && (month_reg >= FIRST_MONTH) &&
    (month_reg <= LAST_MONTH))
    else $error("year or month out of range");

  a_leap_track: assert property (@(posedge clk) disable iff (rst)
    (r25 <= R25_LAST) && (leap_reg == is_leap(year_reg[3:0], r25 == '0)))
    else $error("leap flag or mod 25 residue out of step with year");

  a_refused_holds: assert property (@(posedge clk) disable iff (rst)
    (take && !applied_next) |=> (!applied && (day_reg == $past(day_reg)) &&
    (month_reg == $past(month_reg)) && (year_reg == $past(year_reg))))
    else $error("refused word changed the date");
`endif

endmodule
